>>> rtl/core/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants for the accelerometer fall detector.
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam int AccelW   = 16;
  localparam int TimeW    = 32;
  localparam int FfLevelW = 15;
  localparam int ImpLevelW = 16;
  localparam int TimeoutW = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int SqW      = 31;   // square of a 16-bit signed value, up to 2^30
  localparam int MagW     = 32;   // sum of three squares, up to 3 * 2^30
  localparam int Ff2W     = 2 * FfLevelW;
  localparam int Imp2W    = 2 * ImpLevelW;

  localparam logic [FfLevelW-1:0]  FfLevelRst  = 15'd2048;   // 0.5 g
  localparam logic [ImpLevelW-1:0] ImpLevelRst = 16'd12288;  // 3 g
  localparam logic [TimeoutW-1:0]  TimeoutRst  = 16'd2000;
  localparam logic [Ff2W-1:0]      Ff2Rst      = 30'd4194304;
  localparam logic [Imp2W-1:0]     Imp2Rst     = 32'd150994944;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FREE_FALL = 2'd0,
    CFG_IMPACT    = 2'd1,
    CFG_TIMEOUT   = 2'd2
  } cfg_idx_t;

  // Squared magnitudes of one sample, handed to the decision stage.
  typedef struct packed {
    logic [SqW-1:0]   x2;
    logic [SqW-1:0]   y2;
    logic [SqW-1:0]   z2;
    logic [TimeW-1:0] time_ms;
  } sq_beat_t;

  // Squared thresholds and timeout from the register bank.
  typedef struct packed {
    logic [Ff2W-1:0]     ff2;
    logic [Imp2W-1:0]    imp2;
    logic [TimeoutW-1:0] timeout;
  } thr_t;

endpackage

>>> rtl/core/afd_if.sv
// ----------------------------------------------------------------------------
// afd_if
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------
interface afd_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [afd_pkg::AccelW-1:0]  accel_x;
  logic signed [afd_pkg::AccelW-1:0]  accel_y;
  logic signed [afd_pkg::AccelW-1:0]  accel_z;
  logic        [afd_pkg::TimeW-1:0]   time_ms;

  modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

interface afd_out_if;
  logic valid;
  logic ready;
  logic fall_flag;
  logic armed;

  modport source (output valid, fall_flag, armed, input ready);
  modport sink   (input valid, fall_flag, armed, output ready);
endinterface

>>> rtl/core/accel_fall_detector.sv
// ----------------------------------------------------------------------------
// accel_fall_detector
// Free-fall followed by impact detector on raw three-axis accelerometer beats.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake     Payload
//  in_ch    in   valid/ready   accel_x/y/z (s16), time_ms (u32)
//  out_ch   out  valid/ready   fall_flag (1), armed (1)
//  cfg_*    in   write enable  cfg_index (2), cfg_wdata (16)
//
//  One beat per cycle sustained while out_ch is ready. An accepted sample
//  goes into the input register, then squares, sum, compare and state
//  update run in one pass into the result register.
//  Stalls on out_ch back up through the input register; it refills while the
//  result register drains, so in_ch stays ready whenever a slot is free.
//  Reset (synchronous, active low) disarms, clears the pipeline and restores
//  the levels 2048, 12288 and 2000 ms. The squared thresholds follow a
//  register write in the next cycle.
//
module accel_fall_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  afd_in_if.sink                        in_ch,
  afd_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [afd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [afd_pkg::CfgDataW-1:0]  cfg_wdata
);

  afd_pkg::thr_t     thr;
  afd_pkg::sq_beat_t sq_beat;
  logic              sq_valid;
  logic              dec_ready;

  // Level registers; squared here so the compare needs no square root.
  afd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .thr       (thr)
  );

  // Capture the sample and square each axis.
  afd_square u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_ready (dec_ready),
    .sq_valid (sq_valid),
    .sq_beat  (sq_beat)
  );

  // Sum the squares, advance the arm/impact/timeout state, hold the result.
  afd_decide u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .sq_valid (sq_valid),
    .sq_beat  (sq_beat),
    .thr      (thr),
    .up_ready (dec_ready),
    .out_ch   (out_ch)
  );

endmodule

>>> rtl/core/afd_cfg.sv
// ----------------------------------------------------------------------------
// afd_cfg
// Threshold registers; squares the levels into registered thresholds.
// ----------------------------------------------------------------------------
module afd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [afd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [afd_pkg::CfgDataW-1:0]  cfg_wdata,
  output afd_pkg::thr_t                 thr
);

  logic [afd_pkg::FfLevelW-1:0]  ff_r;
  logic [afd_pkg::ImpLevelW-1:0] imp_r;
  logic [afd_pkg::TimeoutW-1:0]  to_r;
  logic [afd_pkg::Ff2W-1:0]      ff2_r;
  logic [afd_pkg::Imp2W-1:0]     imp2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_r   <= afd_pkg::FfLevelRst;
      imp_r  <= afd_pkg::ImpLevelRst;
      to_r   <= afd_pkg::TimeoutRst;
      ff2_r  <= afd_pkg::Ff2Rst;
      imp2_r <= afd_pkg::Imp2Rst;
    end else begin
      if (cfg_we) begin
        unique case (afd_pkg::cfg_idx_t'(cfg_index))
          afd_pkg::CFG_FREE_FALL: ff_r  <= cfg_wdata[afd_pkg::FfLevelW-1:0];
          afd_pkg::CFG_IMPACT:    imp_r <= cfg_wdata[afd_pkg::ImpLevelW-1:0];
          afd_pkg::CFG_TIMEOUT:   to_r  <= cfg_wdata[afd_pkg::TimeoutW-1:0];
          default: ;  // drop writes beyond the register list
        endcase
      end
      // squares follow the levels in the next cycle
      ff2_r  <= afd_pkg::Ff2W'(ff_r) * afd_pkg::Ff2W'(ff_r);
      imp2_r <= afd_pkg::Imp2W'(imp_r) * afd_pkg::Imp2W'(imp_r);
    end
  end

  assign thr.ff2     = ff2_r;
  assign thr.imp2    = imp2_r;
  assign thr.timeout = to_r;

endmodule

>>> rtl/core/afd_square.sv
// ----------------------------------------------------------------------------
// afd_square
// Input register and per-axis squares for the decision stage.
// ----------------------------------------------------------------------------
module afd_square (
  input  logic              clk,
  input  logic              rst_n,
  afd_in_if.sink            in_ch,
  input  logic              dn_ready,
  output logic              sq_valid,
  output afd_pkg::sq_beat_t sq_beat
);

  logic                              v0_r;
  logic                              en0;
  logic signed [afd_pkg::AccelW-1:0] x_r;
  logic signed [afd_pkg::AccelW-1:0] y_r;
  logic signed [afd_pkg::AccelW-1:0] z_r;
  logic        [afd_pkg::TimeW-1:0]  t_r;
  logic signed [2*afd_pkg::AccelW-1:0] px;
  logic signed [2*afd_pkg::AccelW-1:0] py;
  logic signed [2*afd_pkg::AccelW-1:0] pz;

  assign en0 = !v0_r || dn_ready;
  assign in_ch.ready = en0;

  assign px = x_r * x_r;
  assign py = y_r * y_r;
  assign pz = z_r * z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_ch.valid) begin
      x_r <= in_ch.accel_x;
      y_r <= in_ch.accel_y;
      z_r <= in_ch.accel_z;
      t_r <= in_ch.time_ms;
    end
  end

  always_comb begin
    sq_beat.x2      = px[afd_pkg::SqW-1:0];
    sq_beat.y2      = py[afd_pkg::SqW-1:0];
    sq_beat.z2      = pz[afd_pkg::SqW-1:0];
    sq_beat.time_ms = t_r;
  end

  assign sq_valid = v0_r;

endmodule

>>> rtl/core/afd_decide.sv
// ----------------------------------------------------------------------------
// afd_decide
// Magnitude compare, arm/impact/timeout state, and the result register.
// ----------------------------------------------------------------------------
module afd_decide (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              sq_valid,
  input  afd_pkg::sq_beat_t sq_beat,
  input  afd_pkg::thr_t     thr,
  output logic              up_ready,
  afd_out_if.source         out_ch
);

  logic                          armed_r;
  logic                          armed_nxt;
  logic [afd_pkg::TimeW-1:0]     arm_time_r;
  logic [afd_pkg::TimeW-1:0]     arm_time_nxt;
  logic                          fall_nxt;
  logic                          valid_r;
  logic                          fall_r;
  logic                          adv;
  logic [afd_pkg::MagW-1:0]      mag2;
  logic [afd_pkg::TimeW-1:0]     elapsed;
  logic                          below_ff;
  logic                          above_imp;
  logic                          timed_out;

  assign up_ready = !valid_r || out_ch.ready;
  assign adv      = up_ready && sq_valid;

  assign mag2 = afd_pkg::MagW'(sq_beat.x2) + afd_pkg::MagW'(sq_beat.y2)
              + afd_pkg::MagW'(sq_beat.z2);
  assign below_ff  = mag2 < afd_pkg::MagW'(thr.ff2);
  assign above_imp = mag2 > afd_pkg::MagW'(thr.imp2);
  assign elapsed   = sq_beat.time_ms - arm_time_r;
  assign timed_out = elapsed > afd_pkg::TimeW'(thr.timeout);

  always_comb begin
    armed_nxt    = armed_r;
    arm_time_nxt = arm_time_r;
    fall_nxt     = 1'b0;
    if (!armed_r && below_ff) begin
      armed_nxt    = 1'b1;
      arm_time_nxt = sq_beat.time_ms;
    end else if (armed_r && above_imp) begin
      armed_nxt = 1'b0;
      fall_nxt  = 1'b1;
    end else if (armed_r && timed_out) begin
      armed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= 1'b0;
      arm_time_r <= '0;
      valid_r    <= 1'b0;
      fall_r     <= 1'b0;
    end else begin
      if (up_ready) valid_r <= sq_valid;
      if (adv) begin
        armed_r    <= armed_nxt;
        arm_time_r <= arm_time_nxt;
        fall_r     <= fall_nxt;
      end
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.fall_flag = fall_r;
  assign out_ch.armed     = armed_r;

  a_fall_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && fall_r |-> !armed_r)
    else $error("fall reported while still armed");

  a_arm_records_time: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !armed_r && armed_nxt |=> arm_time_r == $past(sq_beat.time_ms))
    else $error("arm time not recorded on arming");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(armed_r) && $stable(arm_time_r))
    else $error("detector state moved without a beat");

  a_fall_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
    adv && fall_nxt |-> armed_r)
    else $error("fall flagged without prior arming");

endmodule
